FILE: sv/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// Used by u16u8_enc, u16u8_emit, the top level and the checker.
// No dependencies.
`default_nettype none

package u16u8_pkg;

  localparam int UNIT_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int TOTAL_W     = 32;
  localparam int CAP_W       = 31;
  localparam int CP_W        = 21;
  localparam int CNT_W       = 3;
  localparam int MAX_DATA    = 4;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_ADDR_W  = 1;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  localparam cfg_addr_t REG_COUNT_ONLY = 1'b0;
  localparam cfg_addr_t REG_CAPACITY   = 1'b1;

  // top six bits of a surrogate unit
  localparam logic [5:0] HI_SURR_TAG = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;  // 0xDC00..0xDFFF

  localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;
  localparam logic [UNIT_W-1:0] REPL_CHAR = 16'hFFFD;

  // Everything one accepted beat produces.
  typedef struct packed {
    logic [MAX_DATA-1:0][BYTE_W-1:0] bytes;  // bytes[0] goes out first
    logic [CNT_W-1:0]                ndata;  // 0..4 data beats
    logic                            done;   // end-of-string beat follows
    logic                            status; // capacity exceeded
    logic [TOTAL_W-1:0]              total;
  } enc_res_t;

endpackage

`default_nettype wire

FILE: sv/u16u8_enc.sv
// Encoder stage: surrogate pairing, UTF-8 byte formation, byte accounting.
// Holds the per-string state and the configuration registers.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_enc (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire u16u8_pkg::cfg_addr_t          cfg_addr,
  input  wire logic [u16u8_pkg::CAP_W-1:0]   cfg_wdata,
  input  wire logic                          accept,
  input  wire logic [u16u8_pkg::UNIT_W-1:0]  unit,
  input  wire logic                          has_unit,
  input  wire logic                          last_unit,
  output u16u8_pkg::enc_res_t                res
);

  logic                          count_only_r;
  logic [u16u8_pkg::CAP_W-1:0]   cap_r;
  logic                          pend_vld_r, pend_vld_nxt;
  logic [9:0]                    pend_r, pend_nxt;
  logic [u16u8_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic                          ovf_r, ovf_nxt;

  logic                          have_cp;
  logic [u16u8_pkg::CP_W-1:0]    cp;
  logic [u16u8_pkg::CNT_W-1:0]   need;
  logic [u16u8_pkg::TOTAL_W:0]   sum;
  logic [u16u8_pkg::TOTAL_W-1:0] tot_upd;
  logic                          ovf_upd;

  always_comb begin
    have_cp      = 1'b0;
    cp           = '0;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    if (has_unit && !ovf_r) begin
      if (!pend_vld_r) begin
        if (unit[15:10] == u16u8_pkg::HI_SURR_TAG) begin
          pend_vld_nxt = 1'b1;
          pend_nxt     = unit[9:0];
        end else begin
          have_cp = 1'b1;
          cp      = {5'b0, unit};
        end
      end else begin
        have_cp      = 1'b1;
        pend_vld_nxt = 1'b0;
        if (unit[15:10] == u16u8_pkg::LO_SURR_TAG) begin
          cp = {1'b0, pend_r, unit[9:0]} + u16u8_pkg::SUPP_BASE;
        end else begin
          cp = {5'b0, u16u8_pkg::REPL_CHAR};
        end
      end
    end
  end

  always_comb begin
    if (cp > 21'h7F) begin
      if (cp <= 21'h7FF)       need = 3'd2;
      else if (cp <= 21'hFFFF) need = 3'd3;
      else                     need = 3'd4;
    end else begin
      need = 3'd1;
    end
  end

  assign sum = {1'b0, total_r} + {30'b0, need};

  always_comb begin
    res.bytes = '0;
    res.ndata = '0;
    tot_upd   = total_r;
    ovf_upd   = ovf_r;
    if (have_cp) begin
      if (count_only_r) begin
        tot_upd = sum[u16u8_pkg::TOTAL_W] ? '1 : sum[u16u8_pkg::TOTAL_W-1:0];
      end else if (sum > {2'b0, cap_r}) begin
        ovf_upd = 1'b1;
      end else begin
        res.ndata = need;
        tot_upd   = sum[u16u8_pkg::TOTAL_W-1:0];
        case (need)
          3'd1: begin
            res.bytes[0] = cp[7:0];
          end
          3'd2: begin
            res.bytes[0] = {3'b110, cp[10:6]};
            res.bytes[1] = {2'b10, cp[5:0]};
          end
          3'd3: begin
            res.bytes[0] = {4'b1110, cp[15:12]};
            res.bytes[1] = {2'b10, cp[11:6]};
            res.bytes[2] = {2'b10, cp[5:0]};
          end
          default: begin
            res.bytes[0] = {5'b11110, cp[20:18]};
            res.bytes[1] = {2'b10, cp[17:12]};
            res.bytes[2] = {2'b10, cp[11:6]};
            res.bytes[3] = {2'b10, cp[5:0]};
          end
        endcase
      end
    end
    res.done   = last_unit;
    res.status = ovf_upd;
    res.total  = tot_upd;
    // end of string: next string starts clean
    total_nxt  = last_unit ? '0 : tot_upd;
    ovf_nxt    = last_unit ? 1'b0 : ovf_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_only_r <= 1'b0;
      cap_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        u16u8_pkg::REG_COUNT_ONLY: count_only_r <= cfg_wdata[0];
        u16u8_pkg::REG_CAPACITY:   cap_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      pend_r     <= '0;
      total_r    <= '0;
      ovf_r      <= 1'b0;
    end else if (accept) begin
      pend_vld_r <= last_unit ? 1'b0 : pend_vld_nxt;
      pend_r     <= pend_nxt;
      total_r    <= total_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/u16u8_emit.sv
// Result register: holds one item's beats and hands them out one per cycle
// while out_tready is high; takes the next item in the cycle the last beat goes.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_emit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              load,
  input  wire u16u8_pkg::enc_res_t               res,
  output logic                                   ready,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [u16u8_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                   out_tlast,
  output logic                                   out_tuser
);

  logic [u16u8_pkg::MAX_DATA-1:0][u16u8_pkg::BYTE_W-1:0] bytes_r, bytes_nxt;
  logic [u16u8_pkg::CNT_W-1:0]   data_left_r, data_left_nxt;
  logic [u16u8_pkg::CNT_W-1:0]   left_r, left_nxt;
  logic                          stat_r, stat_nxt;
  logic [u16u8_pkg::TOTAL_W-1:0] tot_r, tot_nxt;
  logic                          take;

  assign out_tvalid = (left_r != '0);
  assign out_tlast  = (left_r == 3'd1);
  assign out_tuser  = (data_left_r == '0);
  assign take       = out_tvalid && out_tready;
  assign ready      = !out_tvalid || (take && out_tlast);

  // tdata from bit 0: data_byte[7:0], status[8], total_bytes[40:9], zeros
  assign out_tdata = {7'b0,
                      out_tuser ? tot_r : {u16u8_pkg::TOTAL_W{1'b0}},
                      out_tuser & stat_r,
                      bytes_r[0]};

  always_comb begin
    bytes_nxt     = bytes_r;
    data_left_nxt = data_left_r;
    left_nxt      = left_r;
    stat_nxt      = stat_r;
    tot_nxt       = tot_r;
    if (load) begin
      bytes_nxt     = res.bytes;
      data_left_nxt = res.ndata;
      left_nxt      = res.ndata + {2'b0, res.done};
      stat_nxt      = res.status;
      tot_nxt       = res.total;
    end else if (take) begin
      bytes_nxt = {{u16u8_pkg::BYTE_W{1'b0}}, bytes_r[u16u8_pkg::MAX_DATA-1:1]};
      left_nxt  = left_r - 3'd1;
      if (data_left_r != '0) data_left_nxt = data_left_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      data_left_r <= '0;
    end else begin
      left_r      <= left_nxt;
      data_left_r <= data_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    stat_r  <= stat_nxt;
    tot_r   <= tot_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 encoder, top level.
// Instantiates u16u8_enc and u16u8_emit; depends on u16u8_pkg.
//
// Input stream: one UTF-16 code unit per beat in in_tdata; in_tuser marks
// the unit as present, in_tlast ends the string. A beat with neither does
// nothing. Output stream: one UTF-8 byte per beat, then, for the beat that
// ended the string, a summary beat (out_tuser high) carrying status and
// byte total. out_tlast marks the last output beat of each input beat.
// A high surrogate produces no output until the next code unit arrives.
//
// The first output beat of an input beat appears the cycle after it is
// accepted. An input beat's output beats (0 to 5) hold the output register
// until the last of them is taken; a new input beat is taken in the cycle
// the previous one's final beat leaves, so the input is paced by the single
// output byte lane.
//
// Reset clears configuration, pending surrogate, byte total and error flag.
// When the receiver stalls, the current output beat holds and in_tready
// stays low until its last beat is taken. Configuration writes (cfg_we)
// take effect from the next input beat; write them only while idle.
`default_nettype none

module utf16_to_utf8_encoder (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire u16u8_pkg::cfg_addr_t                 cfg_addr,
  input  wire logic [u16u8_pkg::CAP_W-1:0]          cfg_wdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [u16u8_pkg::UNIT_W-1:0]         in_tdata,  // code_unit[15:0]
  input  wire logic                                 in_tlast,  // last_unit
  input  wire logic                                 in_tuser,  // has_unit
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // out_tdata: data_byte[7:0], status[8], total_bytes[40:9], zero pad
  output logic [u16u8_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                      out_tlast, // is_last
  output logic                                      out_tuser  // is_done
);

  u16u8_pkg::enc_res_t res;
  logic                accept;
  logic                load;

  assign accept = in_tvalid && in_tready;
  assign load   = accept && (res.done || (res.ndata != '0));

  u16u8_enc u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .unit      (in_tdata),
    .has_unit  (in_tuser),
    .last_unit (in_tlast),
    .res       (res)
  );

  u16u8_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .res        (res),
    .ready      (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: sv/u16u8_chk.sv
// Port-level checker for utf16_to_utf8_encoder, bound to the top level.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              in_tlast,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [u16u8_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                              out_tlast,
  input wire logic                              out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("summary beat not marked last");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[u16u8_pkg::OUT_TDATA_W-1:8] == '0)
    else $error("data beat carries status or total");

  a_end_gives_summary: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("end of string produced no output");

endmodule

bind utf16_to_utf8_encoder u16u8_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
